// File: rtl/core/polyline_4d_decoder_assert.svh
// assertion macros used by the checker module pl4d_checker
// ASSERT_CLK: sampled on clk, off while arst_n is low
// ASSERT_RST: sampled on clk, also while arst_n is low
`ifndef POLYLINE_4D_DECODER_ASSERT_SVH
`define POLYLINE_4D_DECODER_ASSERT_SVH

`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/pl4d_pkg.sv
// ----------------------------------------------------------------------------
// pl4d_pkg
// Types and constants shared by the polyline decoder front, back and top.
// ----------------------------------------------------------------------------
package pl4d_pkg;

	localparam int SUM_W      = 32;
	localparam int CHUNK_BITS = 5;

	localparam logic [7:0] BIAS      = 8'd63;
	localparam logic [7:0] MORE_FLAG = 8'd32;
	// bytes at or above this continue the value
	localparam logic [7:0] MORE_MIN  = BIAS + MORE_FLAG;

	typedef logic [CHUNK_BITS-1:0] chunk_t;
	typedef logic [SUM_W-1:0]      sum_t;

	typedef enum logic [1:0] {
		FIELD_LON = 2'd0,
		FIELD_LAT = 2'd1,
		FIELD_ALT = 2'd2,
		FIELD_RAD = 2'd3
	} field_t;

	// classification of one event passed from front to back
	typedef struct packed {
		logic   done;
		field_t field;
		logic   eos;
	} evt_ctl_t;

	typedef struct packed {
		sum_t longitude;
		sum_t latitude;
		sum_t altitude;
		sum_t radius;
		logic last_tuple;
		logic truncated;
	} result_t;

endpackage

// File: rtl/core/polyline_4d_decoder.sv
// a byte that finishes a tuple passes through the event queue and then the result queue before its result shows
// throughput: one byte per cycle while the event queue is not full, set by the combinational chunk merge and sum add
// the event queue and the result queue let front and back stall on their own
// reset: arst_n clears sums, value state and both queues; full low, empty high
// ----------------------------------------------------------------------------
// polyline_4d_decoder
// Streaming decoder for encoded polylines carrying four values per tuple.
// ----------------------------------------------------------------------------
module polyline_4d_decoder #(
	parameter int VALUE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         code_byte,
	input  logic               end_of_string,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] longitude,
	output logic signed [31:0] latitude,
	output logic signed [31:0] altitude,
	output logic signed [31:0] radius,
	output logic               last_tuple,
	output logic               truncated
);

	localparam int EVT_DEPTH = 4;
	localparam int RES_DEPTH = 4;
	localparam int EVT_W     = $bits(pl4d_pkg::evt_ctl_t) + VALUE_BITS;
	localparam int RES_W     = $bits(pl4d_pkg::result_t);

	logic                    accept;
	logic                    evt_push;
	pl4d_pkg::evt_ctl_t      evt_ctl_in;
	logic [VALUE_BITS-1:0]   evt_value_in;
	logic                    evt_empty;
	logic                    evt_pop;
	logic [EVT_W-1:0]        evt_dout;
	pl4d_pkg::evt_ctl_t      evt_ctl_out;
	logic [VALUE_BITS-1:0]   evt_value_out;
	logic                    res_full;
	logic                    res_push;
	pl4d_pkg::result_t       res_in;
	pl4d_pkg::result_t       res_out;
	logic [RES_W-1:0]        res_dout;

	assign accept = push && !full;

	pl4d_front #(
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.code_byte    (code_byte),
		.end_of_string(end_of_string),
		.evt_push     (evt_push),
		.evt_ctl      (evt_ctl_in),
		.evt_value    (evt_value_in)
	);

	pl4d_fifo #(
		.WIDTH(EVT_W),
		.DEPTH(EVT_DEPTH)
	) u_evt_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (evt_push),
		.din   ({evt_ctl_in, evt_value_in}),
		.full  (full),
		.pop   (evt_pop),
		.dout  (evt_dout),
		.empty (evt_empty)
	);

	assign evt_ctl_out   = pl4d_pkg::evt_ctl_t'(evt_dout[EVT_W-1:VALUE_BITS]);
	assign evt_value_out = evt_dout[VALUE_BITS-1:0];

	pl4d_back #(
		.VALUE_BITS(VALUE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.evt_empty(evt_empty),
		.evt_ctl  (evt_ctl_out),
		.evt_value(evt_value_out),
		.evt_pop  (evt_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res_in)
	);

	pl4d_fifo #(
		.WIDTH(RES_W),
		.DEPTH(RES_DEPTH)
	) u_res_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.din   (res_in),
		.full  (res_full),
		.pop   (pop),
		.dout  (res_dout),
		.empty (empty)
	);

	assign res_out    = pl4d_pkg::result_t'(res_dout);
	assign longitude  = res_out.longitude;
	assign latitude   = res_out.latitude;
	assign altitude   = res_out.altitude;
	assign radius     = res_out.radius;
	assign last_tuple = res_out.last_tuple;
	assign truncated  = res_out.truncated;

endmodule

// File: rtl/core/pl4d_fifo.sv
// ----------------------------------------------------------------------------
// pl4d_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module pl4d_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// File: rtl/core/pl4d_front.sv
// ----------------------------------------------------------------------------
// pl4d_front
// Takes code bytes, builds values from 5-bit chunks and emits one event per
// finished value or string end.
// ----------------------------------------------------------------------------
module pl4d_front #(
	parameter int VALUE_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  logic [7:0]              code_byte,
	input  logic                    end_of_string,
	output logic                    evt_push,
	output pl4d_pkg::evt_ctl_t      evt_ctl,
	output logic [VALUE_BITS-1:0]   evt_value
);

	localparam int SHIFT_W = $clog2(VALUE_BITS + pl4d_pkg::CHUNK_BITS);

	pl4d_pkg::field_t        field_q;
	logic [SHIFT_W-1:0]      shift_q;
	logic [VALUE_BITS-1:0]   acc_q;

	logic [7:0]              diff;
	pl4d_pkg::chunk_t        chunk;
	logic                    more;
	logic                    in_range;
	logic [VALUE_BITS-1:0]   acc_next;
	logic [SHIFT_W-1:0]      shift_next;
	pl4d_pkg::field_t        field_next;

	always_comb begin
		diff     = code_byte - pl4d_pkg::BIAS;
		chunk    = diff[pl4d_pkg::CHUNK_BITS-1:0];
		more     = (code_byte >= pl4d_pkg::MORE_MIN);
		// chunks past the value width are dropped
		in_range = (shift_q < SHIFT_W'(VALUE_BITS));
		if (in_range) begin
			acc_next   = acc_q | (VALUE_BITS'(chunk) << shift_q);
			shift_next = shift_q + SHIFT_W'(pl4d_pkg::CHUNK_BITS);
		end else begin
			acc_next   = acc_q;
			shift_next = shift_q;
		end
		unique case (field_q)
			pl4d_pkg::FIELD_LON: field_next = pl4d_pkg::FIELD_LAT;
			pl4d_pkg::FIELD_LAT: field_next = pl4d_pkg::FIELD_ALT;
			pl4d_pkg::FIELD_ALT: field_next = pl4d_pkg::FIELD_RAD;
			pl4d_pkg::FIELD_RAD: field_next = pl4d_pkg::FIELD_LON;
			default:             field_next = pl4d_pkg::FIELD_LON;
		endcase
	end

	assign evt_push      = accept && (!more || end_of_string);
	assign evt_ctl.done  = !more;
	assign evt_ctl.field = field_q;
	assign evt_ctl.eos   = end_of_string;
	assign evt_value     = acc_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_q <= pl4d_pkg::FIELD_LON;
			shift_q <= '0;
			acc_q   <= '0;
		end else if (accept) begin
			if (end_of_string) begin
				field_q <= pl4d_pkg::FIELD_LON;
				shift_q <= '0;
				acc_q   <= '0;
			end else if (!more) begin
				field_q <= field_next;
				shift_q <= '0;
				acc_q   <= '0;
			end else begin
				shift_q <= shift_next;
				acc_q   <= acc_next;
			end
		end
	end

endmodule

// File: rtl/core/pl4d_back.sv
// ----------------------------------------------------------------------------
// pl4d_back
// Zigzag-decodes finished values, keeps the four running sums and forms the
// result tuples.
// ----------------------------------------------------------------------------
module pl4d_back #(
	parameter int VALUE_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    evt_empty,
	input  pl4d_pkg::evt_ctl_t      evt_ctl,
	input  logic [VALUE_BITS-1:0]   evt_value,
	output logic                    evt_pop,
	input  logic                    res_full,
	output logic                    res_push,
	output pl4d_pkg::result_t       res
);

	localparam int EXT_W = (VALUE_BITS > pl4d_pkg::SUM_W) ? VALUE_BITS : pl4d_pkg::SUM_W;

	pl4d_pkg::sum_t          sum_q [4];

	logic [VALUE_BITS-1:0]   half;
	logic [VALUE_BITS-1:0]   decoded;
	logic [EXT_W-1:0]        decoded_ext;
	pl4d_pkg::sum_t          delta;
	pl4d_pkg::sum_t          new_sum;
	logic                    fire;
	logic                    hit_lon;
	logic                    hit_lat;
	logic                    hit_alt;
	logic                    hit_rad;

	always_comb begin
		half        = evt_value >> 1;
		decoded     = evt_value[0] ? ~half : half;
		decoded_ext = EXT_W'(decoded);
		delta       = decoded_ext[pl4d_pkg::SUM_W-1:0];
		new_sum     = sum_q[evt_ctl.field] + delta;

		hit_lon = evt_ctl.done && (evt_ctl.field == pl4d_pkg::FIELD_LON);
		hit_lat = evt_ctl.done && (evt_ctl.field == pl4d_pkg::FIELD_LAT);
		hit_alt = evt_ctl.done && (evt_ctl.field == pl4d_pkg::FIELD_ALT);
		hit_rad = evt_ctl.done && (evt_ctl.field == pl4d_pkg::FIELD_RAD);

		res.longitude  = hit_lon ? new_sum : sum_q[pl4d_pkg::FIELD_LON];
		res.latitude   = hit_lat ? new_sum : sum_q[pl4d_pkg::FIELD_LAT];
		res.altitude   = hit_alt ? new_sum : sum_q[pl4d_pkg::FIELD_ALT];
		res.radius     = hit_rad ? new_sum : sum_q[pl4d_pkg::FIELD_RAD];
		res.last_tuple = evt_ctl.eos;
		// a string may end cleanly only right after altitude or radius
		res.truncated  = evt_ctl.eos && !(hit_alt || hit_rad);
	end

	assign fire     = !evt_empty && !res_full;
	assign evt_pop  = fire;
	assign res_push = fire && (evt_ctl.eos || hit_rad);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				sum_q[i] <= '0;
			end
		end else if (fire) begin
			if (evt_ctl.eos) begin
				for (int i = 0; i < 4; i++) begin
					sum_q[i] <= '0;
				end
			end else if (evt_ctl.done) begin
				sum_q[evt_ctl.field] <= new_sum;
			end
		end
	end

endmodule

// File: rtl/core/pl4d_checker.sv
// ----------------------------------------------------------------------------
// pl4d_checker
// Port-level checks on the polyline decoder, attached by bind.
// ----------------------------------------------------------------------------
`include "polyline_4d_decoder_assert.svh"

module pl4d_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               push,
	input logic               full,
	input logic [7:0]         code_byte,
	input logic               end_of_string,
	input logic               empty,
	input logic               pop,
	input logic signed [31:0] longitude,
	input logic signed [31:0] latitude,
	input logic signed [31:0] altitude,
	input logic signed [31:0] radius,
	input logic               last_tuple,
	input logic               truncated
);

	logic [129:0] res_bits;

	assign res_bits = {longitude, latitude, altitude, radius, last_tuple, truncated};

	// a waiting result stays until its transfer
	`ASSERT_CLK(a_res_held, (!empty && !pop) |=> !empty, "result dropped without transfer")

	`ASSERT_CLK(a_res_stable, (!empty && !pop) |=> $stable(res_bits), "result changed while waiting")

	// a truncated tuple always closes its string
	`ASSERT_CLK(a_trunc_last, !empty |-> (!truncated || last_tuple), "truncated result without last_tuple")

	`ASSERT_RST(a_reset_state, !arst_n |-> (empty && !full), "queues not clear during reset")

endmodule

bind polyline_4d_decoder pl4d_checker u_pl4d_checker (.*);

// File: tb/sv/polyline_4d_decoder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_4d_decoder_checker
// Watches the byte and tuple queues of the decoder. It rebuilds each value from
// its chunks, keeps the running sums, and checks every popped tuple against the
// oldest tuple it has worked out.
// ----------------------------------------------------------------------------
module polyline_4d_decoder_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  logic [7:0]         code_byte,
	input  logic               end_of_string,
	input  logic               empty,
	input  logic               pop,
	input  logic signed [31:0] longitude,
	input  logic signed [31:0] latitude,
	input  logic signed [31:0] altitude,
	input  logic signed [31:0] radius,
	input  logic               last_tuple,
	input  logic               truncated,
	output int                 errors,
	output int                 waiting,
	output int                 tuples_seen,
	output int                 cut_seen
);

	localparam int VALUE_W = 32;

	pl4d_pkg::field_t  fld;
	logic [5:0]        shift;
	logic [31:0]       acc;
	pl4d_pkg::sum_t    lon_sum;
	pl4d_pkg::sum_t    lat_sum;
	pl4d_pkg::sum_t    alt_sum;
	pl4d_pkg::sum_t    rad_sum;
	pl4d_pkg::result_t tuple_q[$];

	int fail_cnt = 0;
	int wait_cnt = 0;
	int seen_cnt = 0;
	int cut_cnt  = 0;

	assign errors      = fail_cnt;
	assign waiting     = wait_cnt;
	assign tuples_seen = seen_cnt;
	assign cut_seen    = cut_cnt;

	function automatic void clear_decode();
		fld     = pl4d_pkg::FIELD_LON;
		shift   = '0;
		acc     = '0;
		lon_sum = '0;
		lat_sum = '0;
		alt_sum = '0;
		rad_sum = '0;
	endfunction

	function automatic void store_tuple(input logic last, input logic cut);
		pl4d_pkg::result_t t;
		t.longitude  = lon_sum;
		t.latitude   = lat_sum;
		t.altitude   = alt_sum;
		t.radius     = rad_sum;
		t.last_tuple = last;
		t.truncated  = cut;
		tuple_q.push_back(t);
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic eos);
		pl4d_pkg::chunk_t chunk;
		logic             more;
		logic [63:0]      placed;
		pl4d_pkg::sum_t   delta;
		logic             emitted;
		chunk   = pl4d_pkg::chunk_t'(b - pl4d_pkg::BIAS);
		more    = (b >= pl4d_pkg::MORE_MIN);
		emitted = 1'b0;
		// chunks past the value width are dropped and the shift stops counting
		if (shift < 6'(VALUE_W)) begin
			placed = 64'(chunk) << shift;
			acc    = acc | placed[31:0];
			shift  = shift + 6'(pl4d_pkg::CHUNK_BITS);
		end
		if (!more) begin
			delta = acc[0] ? ~(acc >> 1) : (acc >> 1);
			acc   = '0;
			shift = '0;
			case (fld)
				pl4d_pkg::FIELD_LON: begin
					lon_sum = lon_sum + delta;
					fld     = pl4d_pkg::FIELD_LAT;
				end
				pl4d_pkg::FIELD_LAT: begin
					lat_sum = lat_sum + delta;
					fld     = pl4d_pkg::FIELD_ALT;
				end
				pl4d_pkg::FIELD_ALT: begin
					alt_sum = alt_sum + delta;
					fld     = pl4d_pkg::FIELD_RAD;
					// string ending on altitude keeps the old radius
					if (eos) begin
						store_tuple(1'b1, 1'b0);
						emitted = 1'b1;
					end
				end
				default: begin
					rad_sum = rad_sum + delta;
					fld     = pl4d_pkg::FIELD_LON;
					store_tuple(eos, 1'b0);
					emitted = 1'b1;
				end
			endcase
		end
		if (eos) begin
			if (!emitted)
				store_tuple(1'b1, 1'b1);
			clear_decode();
		end
	endfunction

	function automatic void check_field(input string name, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_cnt++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pl4d_pkg::result_t want;
		if (!arst_n) begin
			clear_decode();
			tuple_q.delete();
		end else begin
			if (pop && !empty) begin
				seen_cnt++;
				if (truncated === 1'b1)
					cut_cnt++;
				if (tuple_q.size() == 0) begin
					$error("tuple transfer with no tuple expected");
					fail_cnt++;
				end else begin
					want = tuple_q.pop_front();
					check_field("longitude", want.longitude, longitude);
					check_field("latitude", want.latitude, latitude);
					check_field("altitude", want.altitude, altitude);
					check_field("radius", want.radius, radius);
					check_field("last_tuple", 32'(want.last_tuple), 32'(last_tuple));
					check_field("truncated", 32'(want.truncated), 32'(truncated));
				end
			end
			if (push && !full)
				decode_byte(code_byte, end_of_string);
		end
		wait_cnt = tuple_q.size();
	end

endmodule

// File: tb/sv/polyline_4d_decoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_4d_decoder_test
// Feeds the decoder directed corner strings and then random encoded strings,
// mostly well formed, some cut short, some plain noise, with random gaps on
// both queues and long pop hold-offs; the checker beside it judges each tuple.
// ----------------------------------------------------------------------------
module polyline_4d_decoder_test;

	localparam int ITEMS       = 700;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 400;

	logic        clk           = 1'b0;
	// driven low at time zero by the stimulus so the reset edge is seen
	logic        arst_n        = 1'b1;
	logic        push          = 1'b0;
	logic [7:0]  code_byte     = '0;
	logic        end_of_string = 1'b0;
	logic        pop           = 1'b0;
	logic        full;
	logic        empty;
	logic signed [31:0] longitude;
	logic signed [31:0] latitude;
	logic signed [31:0] altitude;
	logic signed [31:0] radius;
	logic        last_tuple;
	logic        truncated;

	int   errors;
	int   waiting;
	int   tuples_seen;
	int   cut_seen;
	int   cycles     = 0;
	int   bytes_sent = 0;
	logic rx_hold    = 1'b0;
	logic tx_fast    = 1'b0;

	logic [7:0] byte_q[$];
	logic       eos_q[$];

	polyline_4d_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.code_byte(code_byte),
		.end_of_string(end_of_string),
		.empty(empty),
		.pop(pop),
		.longitude(longitude),
		.latitude(latitude),
		.altitude(altitude),
		.radius(radius),
		.last_tuple(last_tuple),
		.truncated(truncated)
	);

	polyline_4d_decoder_checker tuple_check (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.code_byte(code_byte),
		.end_of_string(end_of_string),
		.empty(empty),
		.pop(pop),
		.longitude(longitude),
		.latitude(latitude),
		.altitude(altitude),
		.radius(radius),
		.last_tuple(last_tuple),
		.truncated(truncated),
		.errors(errors),
		.waiting(waiting),
		.tuples_seen(tuples_seen),
		.cut_seen(cut_seen)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic void add_byte(input logic [7:0] b, input logic eos);
		byte_q.push_back(b);
		eos_q.push_back(eos);
	endfunction

	// encode one zigzag code, least significant chunk first
	function automatic void add_value(input logic [31:0] code, input logic eos);
		logic [31:0] rest;
		logic [7:0]  c;
		rest = code;
		do begin
			c    = {3'b000, rest[4:0]};
			rest = rest >> 5;
			if (rest != 0)
				c = c | pl4d_pkg::MORE_FLAG;
			add_byte(c + pl4d_pkg::BIAS, eos && (rest == 0));
		end while (rest != 0);
	endfunction

	function automatic logic [31:0] rand_code();
		// mostly short values so that tuples come often
		if ($urandom_range(0, 3) == 0)
			return $urandom >> $urandom_range(0, 31);
		return $urandom >> $urandom_range(20, 31);
	endfunction

	task automatic send_queue();
		int gap;
		while (byte_q.size() != 0) begin
			if (bytes_sent % 40 == 0)
				tx_fast = ($urandom_range(0, 3) == 0);
			gap = (tx_fast || rx_hold) ? 0 : $urandom_range(0, 15);
			repeat (gap) begin
				@(negedge clk);
				push <= 1'b0;
			end
			@(negedge clk);
			push          <= 1'b1;
			code_byte     <= byte_q.pop_front();
			end_of_string <= eos_q.pop_front();
			@(posedge clk);
			while (full)
				@(posedge clk);
			bytes_sent++;
		end
	endtask

	initial begin : receiver
		int   gap;
		int   rx_count;
		logic fast;
		rx_count = 0;
		fast     = 1'b0;
		@(posedge arst_n);
		forever begin
			// long hold-off so the byte side backs up and stalls
			if (rx_count == 10 || rx_count == 50) begin
				rx_hold = 1'b1;
				repeat (HOLD_CYCLES) begin
					@(negedge clk);
					pop <= 1'b0;
				end
				rx_hold = 1'b0;
			end
			if (rx_count % 16 == 0)
				fast = ($urandom_range(0, 3) == 0);
			gap = fast ? 0 : $urandom_range(0, 15);
			repeat (gap) begin
				@(negedge clk);
				pop <= 1'b0;
			end
			@(negedge clk);
			pop <= 1'b1;
			@(posedge clk);
			while (empty)
				@(posedge clk);
			rx_count++;
		end
	end

	initial begin : stimulus
		int   kind;
		int   n;
		int   ntup;
		int   k;
		logic alt_end;
		arst_n <= 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// all-zero tuple, string ends right after radius
		add_byte(pl4d_pkg::BIAS, 1'b0);
		add_byte(pl4d_pkg::BIAS, 1'b0);
		add_byte(pl4d_pkg::BIAS, 1'b0);
		add_byte(pl4d_pkg::BIAS, 1'b1);
		// zero byte and byte below the bias, string ends right after altitude
		add_byte(8'd0, 1'b0);
		add_byte(pl4d_pkg::BIAS - 8'd1, 1'b0);
		add_byte(pl4d_pkg::MORE_MIN - 8'd1, 1'b1);
		// overlong longitude of all ones, the extra chunk is dropped
		repeat (7) add_byte(8'd126, 1'b0);
		add_byte(pl4d_pkg::MORE_MIN - 8'd1, 1'b0);
		add_byte(pl4d_pkg::BIAS, 1'b0);
		add_byte(pl4d_pkg::BIAS, 1'b0);
		add_byte(pl4d_pkg::BIAS, 1'b0);
		// minus one on the most negative longitude wraps the sum
		add_byte(pl4d_pkg::BIAS + 8'd1, 1'b0);
		// end inside the latitude value
		add_byte(pl4d_pkg::MORE_MIN, 1'b1);
		// end after a finished latitude
		add_byte(pl4d_pkg::BIAS, 1'b0);
		add_byte(pl4d_pkg::BIAS, 1'b1);
		// end on the very first byte, inside a value
		add_byte(8'd255, 1'b1);
		send_queue();

		while (bytes_sent < ITEMS) begin
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				n = $urandom_range(1, 6);
				repeat (n - 1) add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
				add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) != 0);
			end else begin
				ntup    = $urandom_range(1, 4);
				alt_end = (kind != 1) && ($urandom_range(0, 2) == 0);
				for (int t = 0; t < ntup; t++) begin
					for (int f = 0; f < 4; f++) begin
						if (kind != 1 && t == ntup - 1 && (f == 3 || (alt_end && f == 2))) begin
							add_value(rand_code(), 1'b1);
							break;
						end
						add_value(rand_code(), 1'b0);
					end
				end
				if (kind == 1) begin
					// broken string: stop after a finished value or inside one
					k = $urandom_range(0, 2);
					for (int f = 0; f < k; f++)
						add_value(rand_code(), (f == k - 1) && $urandom_range(0, 1));
					if (eos_q.size() == 0 || !eos_q[$])
						add_byte(8'($urandom_range(pl4d_pkg::MORE_MIN, 126)), 1'b1);
				end
			end
			send_queue();
		end
		@(negedge clk);
		push <= 1'b0;

		wait (waiting == 0);
		repeat (10) @(posedge clk);
		$display("covered %0d bytes, %0d tuples transferred, %0d of them cut short",
			bytes_sent, tuples_seen, cut_seen);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/pl4d_pkg.sv
rtl/core/pl4d_fifo.sv
rtl/core/pl4d_front.sv
rtl/core/pl4d_back.sv
rtl/core/polyline_4d_decoder.sv
rtl/core/pl4d_checker.sv
tb/sv/polyline_4d_decoder_checker.sv
tb/sv/polyline_4d_decoder_test.sv
